### src/scu_pkg.sv
`default_nettype none

package scu_pkg;

    localparam int TYPE_BITS   = 3;
    localparam int LEN_BITS    = 32;
    localparam int INDEX_BITS  = 16;
    localparam int COUNT_BITS  = 16;

    localparam logic [7:0]            START_CODE_TAIL = 8'h01;
    localparam logic [7:0]            ZERO_BYTE       = 8'h00;
    localparam int                    HDR_SKIP_BIT    = 7;
    localparam int                    HDR_TYPE_LSB    = 4;
    localparam logic [1:0]            ZERO_RUN_FULL   = 2'd2;
    localparam logic [COUNT_BITS-1:0] MAX_UNITS_RESET = 16'hFFFF;
    localparam logic [INDEX_BITS-1:0] INDEX_LIMIT     = 16'hFFFF;

    typedef struct packed {
        logic                  closed_by_end;
        logic [INDEX_BITS-1:0] unit_index;
        logic [LEN_BITS-1:0]   payload_length;
        logic [LEN_BITS-1:0]   payload_offset;
        logic [TYPE_BITS-1:0]  unit_type;
    } t_result;

endpackage

`default_nettype wire

### src/start_code_unit_splitter.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata: byte_value[7:0]; tlast: final_byte
// m_axis    out  tdata: offset[31:0], length[63:32], index[79:64]; tuser: type[2:0], end[3]
// cfg       in   i_cfg_wr_data: max_units, written when i_cfg_wr_en is high
//
// One input beat is taken every clock while the output queue is not full; a beat passes
// an input register, then the scanner logic, and its result leaves through a two-entry output queue.
// A result reaches m_axis once its byte has passed the input register and been written into the output queue.
// Reset is synchronous; the unit limit returns to 65535 and all stream state clears.
// When the output queue is full, the scanner holds and s_axis_tready drops once the input register holds a beat.

`default_nettype none

module start_code_unit_splitter #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_value[7:0]
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,   // payload_offset, payload_length, unit_index
    output logic [3:0]       m_axis_tuser    // unit_type[2:0], closed_by_end[3]
);

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             in_final;
    logic             fifo_full;
    logic             fire;
    logic             res_valid;
    scu_pkg::t_result res;
    scu_pkg::t_result out_res;

    assign fire = in_valid && !fifo_full;

    scu_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_final (s_axis_tlast),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_byte  (in_byte),
        .o_final (in_final)
    );

    scu_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_fire        (fire),
        .i_byte        (in_byte),
        .i_final       (in_final),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    scu_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_full  (fifo_full),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {out_res.unit_index, out_res.payload_length, out_res.payload_offset};
    assign m_axis_tuser = {out_res.closed_by_end, out_res.unit_type};

endmodule

`default_nettype wire

### src/scu_in_stage.sv
`default_nettype none

module scu_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_final,
    input  wire logic       i_take,
    output logic            o_valid,
    output logic [7:0]      o_byte,
    output logic            o_final
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_final;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_final = r_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte  <= i_byte;
            r_final <= i_final;
        end
    end

endmodule

`default_nettype wire

### src/scu_core.sv
`default_nettype none

module scu_core #(
    parameter int OFFSET_BITS = 32
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [scu_pkg::COUNT_BITS-1:0]        i_cfg_wr_data,
    input  wire logic                                  i_fire,
    input  wire logic [7:0]                            i_byte,
    input  wire logic                                  i_final,
    output logic                                       o_res_valid,
    output scu_pkg::t_result                           o_res
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_UNIT,
        PH_DONE
    } t_phase;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] SC_BACK = OFFSET_BITS'(2);
    localparam logic [OFFSET_BITS-1:0] ONE     = OFFSET_BITS'(1);

    t_phase                            r_phase, n_phase;
    logic [1:0]                        r_zero_run, n_zero_run;
    logic [OFFSET_BITS-1:0]            r_pos, n_pos;
    logic [OFFSET_BITS-1:0]            r_start, n_start;
    logic [scu_pkg::TYPE_BITS-1:0]     r_type, n_type;
    logic [scu_pkg::INDEX_BITS-1:0]    r_emitted, n_emitted;
    logic [scu_pkg::COUNT_BITS-1:0]    r_max_units;

    logic                              start_code;
    logic [1:0]                        zero_next;
    logic [OFFSET_BITS-1:0]            pos_inc;
    logic [OFFSET_BITS:0]              diff;
    logic                              borrow;
    logic [OFFSET_BITS-1:0]            span;
    logic [OFFSET_BITS-1:0]            len_code;
    logic [OFFSET_BITS-1:0]            len_end;
    logic                              res_valid;
    scu_pkg::t_result                  res;

    assign start_code = (i_byte == scu_pkg::START_CODE_TAIL) &&
                        (r_zero_run == scu_pkg::ZERO_RUN_FULL);
    assign zero_next  = (i_byte != scu_pkg::ZERO_BYTE) ? 2'd0 :
                        (r_zero_run == scu_pkg::ZERO_RUN_FULL) ? scu_pkg::ZERO_RUN_FULL :
                        r_zero_run + 2'd1;
    assign pos_inc    = (r_pos == POS_MAX) ? r_pos : r_pos + ONE;

    // Payload length from the distance between the current byte and the payload start.
    assign diff     = {1'b0, r_pos} - {1'b0, r_start};
    assign borrow   = diff[OFFSET_BITS];
    assign span     = diff[OFFSET_BITS-1:0];
    assign len_code = (!borrow && (span > SC_BACK)) ? span - SC_BACK : '0;
    assign len_end  = borrow ? '0 : ((r_pos == POS_MAX) ? span : span + ONE);

    always_comb begin
        n_phase    = r_phase;
        n_zero_run = r_zero_run;
        n_pos      = pos_inc;
        n_start    = r_start;
        n_type     = r_type;
        n_emitted  = r_emitted;
        res_valid  = 1'b0;
        res.unit_type      = r_type;
        res.payload_offset = 32'(r_start);
        res.payload_length = 32'(len_code);
        res.unit_index     = r_emitted;
        res.closed_by_end  = 1'b0;

        case (r_phase)
            PH_HUNT: begin
                if (start_code) begin
                    n_phase = PH_HEADER;
                end
                n_zero_run = zero_next;
            end
            PH_HEADER: begin
                n_zero_run = 2'd0;
                if (i_byte[scu_pkg::HDR_SKIP_BIT]) begin
                    n_phase = PH_HUNT;
                end else if (r_emitted >= r_max_units) begin
                    n_phase = PH_DONE;
                end else begin
                    n_type  = i_byte[scu_pkg::HDR_TYPE_LSB +: scu_pkg::TYPE_BITS];
                    n_start = pos_inc;
                    n_phase = PH_UNIT;
                end
            end
            PH_UNIT: begin
                if (start_code) begin
                    res_valid  = 1'b1;
                    n_phase    = PH_HEADER;
                    n_zero_run = 2'd0;
                    if (r_emitted != scu_pkg::INDEX_LIMIT) begin
                        n_emitted = r_emitted + 1'b1;
                    end
                end else begin
                    n_zero_run = zero_next;
                end
            end
            PH_DONE: begin
                n_zero_run = zero_next;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase

        if (i_final) begin
            if (n_phase == PH_UNIT && !res_valid) begin
                res_valid          = 1'b1;
                res.unit_type      = n_type;
                res.payload_offset = 32'(n_start);
                res.payload_length = (r_phase == PH_HEADER) ? '0 : 32'(len_end);
                res.closed_by_end  = 1'b1;
            end
            n_phase    = PH_HUNT;
            n_zero_run = 2'd0;
            n_pos      = '0;
            n_start    = '0;
            n_type     = '0;
            n_emitted  = '0;
        end
    end

    assign o_res_valid = i_fire && res_valid;
    assign o_res       = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_zero_run  <= 2'd0;
            r_pos       <= '0;
            r_start     <= '0;
            r_type      <= '0;
            r_emitted   <= '0;
            r_max_units <= scu_pkg::MAX_UNITS_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_units <= i_cfg_wr_data;
            end
            if (i_fire) begin
                r_phase    <= n_phase;
                r_zero_run <= n_zero_run;
                r_pos      <= n_pos;
                r_start    <= n_start;
                r_type     <= n_type;
                r_emitted  <= n_emitted;
            end
        end
    end

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_final |=> r_phase == PH_HUNT && r_pos == '0 && r_emitted == '0)
        else $error("stream state not cleared after the final beat");

    a_code_close_in_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.closed_by_end |-> r_phase == PH_UNIT && start_code)
        else $error("unit closed by a start code outside an open unit");

    a_zero_run_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_zero_run != 2'd3)
        else $error("zero run counter passed its saturation value");

    a_pos_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_final |=> r_pos != '0)
        else $error("byte position did not advance");

    a_end_close_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.closed_by_end |-> i_final)
        else $error("unit closed by stream end without a final beat");

endmodule

`default_nettype wire

### src/scu_out_fifo.sv
`default_nettype none

module scu_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire scu_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output scu_pkg::t_result      o_data
);

    scu_pkg::t_result r_mem [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_count;
    logic             pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push && !pop) begin
                r_count <= r_count + 2'd1;
            end else if (pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### sim/start_code_unit_splitter_check.sv
`timescale 1ns / 1ps

module start_code_unit_splitter_check (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // byte_value[7:0]
    input  wire logic        s_axis_tlast,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [79:0] m_axis_tdata,   // payload_offset, payload_length, unit_index
    input  wire logic [3:0]  m_axis_tuser,   // unit_type[2:0], closed_by_end[3]
    output int               o_fail_count,
    output int               o_pending
);

    typedef enum logic [1:0] {
        SCAN_HUNT,
        SCAN_HEADER,
        SCAN_UNIT,
        SCAN_DONE
    } t_scan_phase;

    localparam logic [scu_pkg::LEN_BITS-1:0] POS_LIMIT = '1;
    localparam int                           REPORT_LIMIT = 10;

    t_scan_phase                      scan_phase;
    logic [1:0]                       zeros_seen;
    logic [scu_pkg::LEN_BITS-1:0]     cur_pos;
    logic [scu_pkg::LEN_BITS-1:0]     open_start;
    logic [scu_pkg::TYPE_BITS-1:0]    open_type;
    logic [scu_pkg::INDEX_BITS-1:0]   units_done;
    logic [scu_pkg::COUNT_BITS-1:0]   unit_limit;
    scu_pkg::t_result                 unit_reports[$];

    function automatic logic [scu_pkg::LEN_BITS-1:0] pos_inc(
        input logic [scu_pkg::LEN_BITS-1:0] v);
        return (v == POS_LIMIT) ? v : v + 1'b1;
    endfunction

    function automatic logic [scu_pkg::LEN_BITS-1:0] span(
        input logic [scu_pkg::LEN_BITS-1:0] stop,
        input logic [scu_pkg::LEN_BITS-1:0] start);
        return (stop > start) ? stop - start : '0;
    endfunction

    function automatic void clear_stream();
        scan_phase = SCAN_HUNT;
        zeros_seen = '0;
        cur_pos    = '0;
        open_start = '0;
        open_type  = '0;
        units_done = '0;
    endfunction

    function automatic void push_report(input logic [scu_pkg::LEN_BITS-1:0] len,
                                        input logic by_end);
        scu_pkg::t_result r;
        r.unit_type      = open_type;
        r.payload_offset = open_start;
        r.payload_length = len;
        r.unit_index     = units_done;
        r.closed_by_end  = by_end;
        unit_reports.push_back(r);
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic fin);
        logic [scu_pkg::LEN_BITS-1:0] pos;
        logic                         start_code;
        logic [1:0]                   next_zeros;
        logic                         reported;
        pos        = cur_pos;
        reported   = 1'b0;
        start_code = (b == scu_pkg::START_CODE_TAIL) &&
                     (zeros_seen == scu_pkg::ZERO_RUN_FULL);
        if (b != scu_pkg::ZERO_BYTE) begin
            next_zeros = '0;
        end else if (zeros_seen == scu_pkg::ZERO_RUN_FULL) begin
            next_zeros = scu_pkg::ZERO_RUN_FULL;
        end else begin
            next_zeros = zeros_seen + 2'd1;
        end
        case (scan_phase)
            SCAN_HUNT: begin
                if (start_code) begin
                    scan_phase = SCAN_HEADER;
                end
                zeros_seen = next_zeros;
            end
            SCAN_HEADER: begin
                zeros_seen = '0;
                if (b[scu_pkg::HDR_SKIP_BIT]) begin
                    scan_phase = SCAN_HUNT;
                end else if (units_done >= unit_limit) begin
                    scan_phase = SCAN_DONE;
                end else begin
                    open_type  = b[scu_pkg::HDR_TYPE_LSB +: scu_pkg::TYPE_BITS];
                    open_start = pos_inc(pos);
                    scan_phase = SCAN_UNIT;
                end
            end
            SCAN_UNIT: begin
                if (start_code) begin
                    push_report(span((pos >= 2) ? pos - 2 : '0, open_start), 1'b0);
                    reported = 1'b1;
                    if (units_done != scu_pkg::INDEX_LIMIT) begin
                        units_done = units_done + 1'b1;
                    end
                    scan_phase = SCAN_HEADER;
                    zeros_seen = '0;
                end else begin
                    zeros_seen = next_zeros;
                end
            end
            default: begin
                zeros_seen = next_zeros;
            end
        endcase
        if (fin) begin
            if (scan_phase == SCAN_UNIT && !reported) begin
                push_report(span(pos_inc(pos), open_start), 1'b1);
            end
            clear_stream();
        end else begin
            cur_pos = pos_inc(pos);
        end
    endfunction

    function automatic void check_report();
        scu_pkg::t_result got;
        scu_pkg::t_result want;
        got.unit_type      = m_axis_tuser[2:0];
        got.closed_by_end  = m_axis_tuser[3];
        got.payload_offset = m_axis_tdata[31:0];
        got.payload_length = m_axis_tdata[63:32];
        got.unit_index     = m_axis_tdata[79:64];
        if (unit_reports.size() == 0) begin
            if (o_fail_count < REPORT_LIMIT) begin
                $display("%0t: unexpected unit: type %0d offset %0d length %0d index %0d end %0d",
                         $time, got.unit_type, got.payload_offset, got.payload_length,
                         got.unit_index, got.closed_by_end);
            end
            o_fail_count++;
            return;
        end
        want = unit_reports.pop_front();
        if (got.unit_type !== want.unit_type || got.payload_offset !== want.payload_offset ||
            got.payload_length !== want.payload_length ||
            got.unit_index !== want.unit_index ||
            got.closed_by_end !== want.closed_by_end) begin
            if (o_fail_count < REPORT_LIMIT) begin
                $display("%0t: unit mismatch", $time);
                $display("  expected type %0d offset %0d length %0d index %0d end %0d",
                         want.unit_type, want.payload_offset, want.payload_length,
                         want.unit_index, want.closed_by_end);
                $display("  actual   type %0d offset %0d length %0d index %0d end %0d",
                         got.unit_type, got.payload_offset, got.payload_length,
                         got.unit_index, got.closed_by_end);
            end
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_fail_count = 0;
            unit_limit   = scu_pkg::MAX_UNITS_RESET;
            clear_stream();
            unit_reports.delete();
        end else begin
            if (i_cfg_wr_en) begin
                unit_limit = i_cfg_wr_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                scan_byte(s_axis_tdata, s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                check_report();
            end
        end
        o_pending = unit_reports.size();
    end

endmodule

### sim/start_code_unit_splitter_test.sv
`timescale 1ns / 1ps

module start_code_unit_splitter_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PHASE_BYTES = 40;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_CHOKED,
        RX_COIN
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [15:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // byte_value[7:0]
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;         // payload_offset, payload_length, unit_index
    logic [3:0]  m_axis_tuser;         // unit_type[2:0], closed_by_end[3]

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          rx_cycle = 0;
    t_rx_mode    rx_mode = RX_OPEN;
    int          burst_left = 0;
    logic [7:0]  stream_bytes[$];
    logic [15:0] limit_plan[$];
    int          phase_sent;

    start_code_unit_splitter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    start_code_unit_splitter_check checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 300 == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_OPEN:    m_axis_tready <= 1'b1;
            RX_LIGHT:   m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_CHOKED:  m_axis_tready <= ((rx_cycle % 16) < 3);
            default:    m_axis_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    function automatic logic [7:0] stream_byte();
        case ($urandom_range(0, 5))
            0, 1:    return 8'h00;
            2:       return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
            burst_left = $urandom_range(0, 24);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_stream(input bit hold_midway);
        int k;
        for (k = 0; k < stream_bytes.size(); k++) begin
            if (hold_midway && k == stream_bytes.size() / 2 && k > 0) begin
                wait_drained();
            end
            send_beat(stream_bytes[k], k == stream_bytes.size() - 1);
        end
        phase_sent += stream_bytes.size();
    endtask

    task automatic set_max_units(input logic [15:0] value);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    task automatic make_stream();
        int units;
        int u;
        int len;
        stream_bytes.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 30)) stream_bytes.push_back(stream_byte());
        end else begin
            units = $urandom_range(0, 5);
            repeat ($urandom_range(0, 3)) stream_bytes.push_back(stream_byte());
            for (u = 0; u < units; u++) begin
                if ($urandom_range(0, 9) == 0) begin
                    stream_bytes.push_back(8'h00);
                end else begin
                    repeat (($urandom_range(0, 4) == 0) ? $urandom_range(3, 5) : 2)
                        stream_bytes.push_back(8'h00);
                end
                stream_bytes.push_back(8'h01);
                if ($urandom_range(0, 5) == 0) begin
                    stream_bytes.push_back({1'b1, 7'($urandom_range(0, 127))});
                end else begin
                    stream_bytes.push_back({1'b0, 7'($urandom_range(0, 127))});
                end
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 10);
                repeat (len) stream_bytes.push_back(stream_byte());
            end
            case ($urandom_range(0, 4))
                0: begin
                    stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h01);
                end
                1: begin
                    stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h01);
                    stream_bytes.push_back(8'($urandom_range(0, 255)));
                end
                2: begin
                    stream_bytes.push_back(8'h00);
                    stream_bytes.push_back(8'h00);
                end
                default: begin
                end
            endcase
        end
        if (stream_bytes.size() == 0) begin
            stream_bytes.push_back(stream_byte());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h70, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
                         8'h80, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01, 8'h05};
        send_stream(1'b0);
        stream_bytes = '{8'h12, 8'h00, 8'h00, 8'h01, 8'h3F, 8'h01};
        send_stream(1'b0);
        stream_bytes = '{8'h00, 8'h00, 8'h01, 8'h60, 8'hAB, 8'h00, 8'h00, 8'h01};
        send_stream(1'b0);
        stream_bytes = '{8'hFF};
        send_stream(1'b0);

        limit_plan = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'($urandom_range(0, 7)), 16'd3,
                       16'hFFFF};
        foreach (limit_plan[p]) begin
            set_max_units(limit_plan[p]);
            phase_sent = 0;
            make_stream();
            send_stream(1'b1);
            while (phase_sent < PHASE_BYTES) begin
                make_stream();
                send_stream($urandom_range(0, 19) == 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
